// ----- rtl/ymd_date_parse_and_classify_defines.svh -----
// Assertion macros shared by the date parser RTL.
`ifndef YMD_DATE_PARSE_AND_CLASSIFY_DEFINES_SVH
`define YMD_DATE_PARSE_AND_CLASSIFY_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked property, held off while reset is asserted
`define YMDPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Condition that must never be seen at a clock edge
`define YMDPC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);
`else
`define YMDPC_ASSERT(lbl, prop, msg)
`define YMDPC_NEVER(lbl, expr, msg)
`endif

`endif

// ----- rtl/ymdpc_pkg.sv -----
package ymdpc_pkg;

  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned MD_W        = 7;
  localparam int unsigned YCNT_W      = 3;
  localparam int unsigned MDCNT_W     = 2;
  localparam int unsigned YEAR_DIGITS = 4;
  localparam int unsigned MD_DIGITS   = 2;
  localparam int unsigned Q_DEPTH_DEF = 2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [MD_W-1:0] MONTHS_IN_YEAR = 7'd12;
  localparam logic [MD_W-1:0] MONTH_FEB      = 7'd2;
  localparam logic [MD_W-1:0] DAYS_MAX       = 7'd31;
  localparam logic [MD_W-1:0] FEB_DAYS       = 7'd28;
  localparam logic [MD_W-1:0] FEB_LEAP_DAYS  = 7'd29;

  typedef enum logic [3:0] {
    PH_LEAD,
    PH_YEAR,
    PH_PRE_D1,
    PH_POST_D1,
    PH_MONTH,
    PH_PRE_D2,
    PH_POST_D2,
    PH_DAY,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD,
    ST_MISSING,
    ST_PART,
    ST_ILLOGICAL
  } status_t;

  // One parsed string as handed from the scanner to the classifier
  typedef struct packed {
    logic              ok;
    logic [YEAR_W-1:0] year;
    logic [MD_W-1:0]   month;
    logic              month_present;
    logic [MD_W-1:0]   day;
    logic              day_present;
    logic              leap;
  } date_rec_t;

  function automatic logic [MD_W-1:0] days_in_month(input logic [MD_W-1:0] m);
    logic [MD_W-1:0] d;
    case (m)
      7'd2:                    d = FEB_DAYS;
      7'd4, 7'd6, 7'd9, 7'd11: d = 7'd30;
      default:                 d = DAYS_MAX;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/ymdpc_in_if.sv -----
interface ymdpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// ----- rtl/ymdpc_out_if.sv -----
interface ymdpc_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] year;
  logic [6:0]  month;
  logic [6:0]  day;
  logic        month_present;
  logic        day_present;
  logic        parse_ok;
  logic [1:0]  status;

  modport source (output valid, output year, output month, output day,
                  output month_present, output day_present, output parse_ok,
                  output status, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input month_present, input day_present, input parse_ok,
                  input status, output ready);
endinterface

// ----- rtl/ymdpc_front.sv -----
`include "ymd_date_parse_and_classify_defines.svh"

module ymdpc_front import ymdpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ymdpc_in_if.sink   in_chan,
  input  logic       q_full,
  output logic       q_push,
  output date_rec_t  q_rec
);

  phase_t               phase_r, phase_nxt;
  logic [YEAR_W-1:0]    year_acc_r, year_acc_nxt;
  logic [YCNT_W-1:0]    year_cnt_r, year_cnt_nxt;
  logic [MD_W-1:0]      month_acc_r, month_acc_nxt;
  logic [MDCNT_W-1:0]   month_cnt_r, month_cnt_nxt;
  logic [MD_W-1:0]      day_acc_r, day_acc_nxt;
  logic [MDCNT_W-1:0]   day_cnt_r, day_cnt_nxt;
  logic [3:0][3:0]      ydig_r, ydig_nxt;

  logic                 xfer, xfer_last;
  logic                 is_ws, is_dig, is_dash;
  logic [3:0]           dval;
  logic                 year_dig, month_dig, day_dig;
  logic                 year_full, month_full, day_full;
  logic                 ok;
  logic [4:0]           lo_sum, hi_sum;
  logic                 century, leap;

  assign in_chan.ready = !q_full;
  assign xfer          = in_chan.valid && in_chan.ready;
  assign xfer_last     = xfer && in_chan.last;

  assign is_ws   = (in_chan.ch == CH_SPACE) || (in_chan.ch >= CH_TAB && in_chan.ch <= CH_CR);
  assign is_dig  = (in_chan.ch >= CH_ZERO) && (in_chan.ch <= CH_NINE);
  assign is_dash = (in_chan.ch == CH_DASH);
  assign dval    = in_chan.ch[3:0];

  assign year_dig  = is_dig && (phase_r == PH_LEAD || phase_r == PH_YEAR);
  assign month_dig = is_dig && (phase_r == PH_POST_D1 || phase_r == PH_MONTH);
  assign day_dig   = is_dig && (phase_r == PH_POST_D2 || phase_r == PH_DAY);

  assign year_full  = (year_cnt_r >= YCNT_W'(YEAR_DIGITS));
  assign month_full = (month_cnt_r >= MDCNT_W'(MD_DIGITS));
  assign day_full   = (day_cnt_r >= MDCNT_W'(MD_DIGITS));

  // Next scan phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_LEAD: begin
        if (!is_ws) phase_nxt = is_dig ? PH_YEAR : PH_FAIL;
      end
      PH_YEAR: begin
        if (is_dig)       phase_nxt = PH_YEAR;
        else if (is_ws)   phase_nxt = PH_PRE_D1;
        else if (is_dash) phase_nxt = PH_POST_D1;
        else              phase_nxt = PH_FAIL;
      end
      PH_PRE_D1: begin
        if (!is_ws) phase_nxt = is_dash ? PH_POST_D1 : PH_FAIL;
      end
      PH_POST_D1: begin
        if (!is_ws) begin
          if (is_dig)       phase_nxt = PH_MONTH;
          else if (is_dash) phase_nxt = PH_POST_D2;
          else              phase_nxt = PH_FAIL;
        end
      end
      PH_MONTH: begin
        if (is_dig)       phase_nxt = PH_MONTH;
        else if (is_ws)   phase_nxt = PH_PRE_D2;
        else if (is_dash) phase_nxt = PH_POST_D2;
        else              phase_nxt = PH_FAIL;
      end
      PH_PRE_D2: begin
        if (!is_ws) phase_nxt = is_dash ? PH_POST_D2 : PH_FAIL;
      end
      PH_POST_D2: begin
        if (!is_ws) phase_nxt = is_dig ? PH_DAY : PH_DONE;
      end
      PH_DAY: begin
        if (!is_dig) phase_nxt = PH_DONE;
      end
      PH_DONE: phase_nxt = PH_DONE;
      default: phase_nxt = PH_FAIL;
    endcase
    // a digit beyond the field's width kills the parse
    if ((year_dig && year_full) || (month_dig && month_full) || (day_dig && day_full))
      phase_nxt = PH_FAIL;
  end

  // Decimal accumulators; stop adding once a field is full, saturate the count
  always_comb begin
    year_acc_nxt  = year_acc_r;
    year_cnt_nxt  = year_cnt_r;
    month_acc_nxt = month_acc_r;
    month_cnt_nxt = month_cnt_r;
    day_acc_nxt   = day_acc_r;
    day_cnt_nxt   = day_cnt_r;
    ydig_nxt      = ydig_r;
    if (year_dig) begin
      if (!year_full) begin
        year_acc_nxt = YEAR_W'(year_acc_r * YEAR_W'(10) + YEAR_W'(dval));
        ydig_nxt     = {ydig_r[2:0], dval};
      end
      if (year_cnt_r <= YCNT_W'(YEAR_DIGITS)) year_cnt_nxt = year_cnt_r + 1'b1;
    end
    if (month_dig) begin
      if (!month_full) month_acc_nxt = MD_W'(month_acc_r * MD_W'(10) + MD_W'(dval));
      if (month_cnt_r != '1) month_cnt_nxt = month_cnt_r + 1'b1;
    end
    if (day_dig) begin
      if (!day_full) day_acc_nxt = MD_W'(day_acc_r * MD_W'(10) + MD_W'(dval));
      if (day_cnt_r != '1) day_cnt_nxt = day_cnt_r + 1'b1;
    end
  end

  // Leap test from the last four year digits: two-digit pairs mod 4
  assign lo_sum  = {ydig_nxt[1], 1'b0} + {1'b0, ydig_nxt[0]};
  assign hi_sum  = {ydig_nxt[3], 1'b0} + {1'b0, ydig_nxt[2]};
  assign century = (ydig_nxt[1] == 4'd0) && (ydig_nxt[0] == 4'd0);
  assign leap    = century ? (hi_sum[1:0] == 2'd0) : (lo_sum[1:0] == 2'd0);

  always_comb begin
    ok                  = phase_nxt inside {PH_POST_D2, PH_DAY, PH_DONE};
    q_rec.ok            = ok;
    q_rec.year          = ok ? year_acc_nxt : '0;
    q_rec.month_present = ok && (month_cnt_nxt != '0);
    q_rec.month         = q_rec.month_present ? month_acc_nxt : '0;
    q_rec.day_present   = ok && (day_cnt_nxt != '0);
    q_rec.day           = q_rec.day_present ? day_acc_nxt : '0;
    q_rec.leap          = leap;
  end

  assign q_push = xfer_last;

  always_ff @(posedge clk) begin
    if (!rst_n || xfer_last) begin
      phase_r     <= PH_LEAD;
      year_acc_r  <= '0;
      year_cnt_r  <= '0;
      month_acc_r <= '0;
      month_cnt_r <= '0;
      day_acc_r   <= '0;
      day_cnt_r   <= '0;
      ydig_r      <= '0;
    end else if (xfer) begin
      phase_r     <= phase_nxt;
      year_acc_r  <= year_acc_nxt;
      year_cnt_r  <= year_cnt_nxt;
      month_acc_r <= month_acc_nxt;
      month_cnt_r <= month_cnt_nxt;
      day_acc_r   <= day_acc_nxt;
      day_cnt_r   <= day_cnt_nxt;
      ydig_r      <= ydig_nxt;
    end
  end

  `YMDPC_ASSERT(a_front_restart, q_push |=> (phase_r == PH_LEAD && year_cnt_r == '0), "scan not restarted after last character")
  `YMDPC_ASSERT(a_front_fail_final, (phase_r == PH_FAIL && !q_push) |=> (phase_r == PH_FAIL), "failed parse recovered mid-string")
  `YMDPC_NEVER(a_front_push_full, q_push && q_full, "record pushed into a full queue")

endmodule

// ----- rtl/ymdpc_queue.sv -----
`include "ymd_date_parse_and_classify_defines.svh"

module ymdpc_queue import ymdpc_pkg::*; #(
  parameter int unsigned DEPTH = Q_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  date_rec_t wr_rec,
  output logic      full,
  input  logic      pop,
  output date_rec_t rd_rec,
  output logic      valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  date_rec_t           mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign valid  = (cnt_r != '0);
  assign rd_rec = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `YMDPC_NEVER(a_q_pop_empty, pop && !valid, "pop from an empty queue")
  `YMDPC_NEVER(a_q_push_full, push && full, "push into a full queue")
  `YMDPC_NEVER(a_q_overfill, cnt_r > CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// ----- rtl/ymdpc_back.sv -----
`include "ymd_date_parse_and_classify_defines.svh"

module ymdpc_back import ymdpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  date_rec_t   q_rec,
  output logic        q_pop,
  ymdpc_out_if.source out_chan
);

  logic              out_valid_r;
  logic [YEAR_W-1:0] year_r;
  logic [MD_W-1:0]   month_r, day_r;
  logic              month_present_r, day_present_r, parse_ok_r;
  status_t           status_r, status_nxt;

  logic              month_bad, day_bad;

  assign q_pop = q_valid && (!out_valid_r || out_chan.ready);

  assign month_bad = (q_rec.month == '0) || (q_rec.month > MONTHS_IN_YEAR);
  assign day_bad   = (q_rec.day == '0) || (q_rec.day > DAYS_MAX);

  always_comb begin
    if (!q_rec.ok)
      status_nxt = ST_MISSING;
    else if (!q_rec.month_present && !q_rec.day_present)
      status_nxt = ST_PART;
    else if (!q_rec.day_present)
      status_nxt = month_bad ? ST_ILLOGICAL : ST_PART;
    else if (!q_rec.month_present)
      status_nxt = day_bad ? ST_ILLOGICAL : ST_PART;
    else if (month_bad || day_bad)
      status_nxt = ST_ILLOGICAL;
    else if (q_rec.month != MONTH_FEB)
      status_nxt = (q_rec.day > days_in_month(q_rec.month)) ? ST_ILLOGICAL : ST_GOOD;
    else if (q_rec.day <= FEB_DAYS)
      status_nxt = ST_GOOD;
    else if (q_rec.day > FEB_LEAP_DAYS)
      status_nxt = ST_ILLOGICAL;
    else
      status_nxt = q_rec.leap ? ST_GOOD : ST_ILLOGICAL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      year_r          <= q_rec.year;
      month_r         <= q_rec.month;
      day_r           <= q_rec.day;
      month_present_r <= q_rec.month_present;
      day_present_r   <= q_rec.day_present;
      parse_ok_r      <= q_rec.ok;
      status_r        <= status_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.year          = year_r;
  assign out_chan.month         = month_r;
  assign out_chan.day           = day_r;
  assign out_chan.month_present = month_present_r;
  assign out_chan.day_present   = day_present_r;
  assign out_chan.parse_ok      = parse_ok_r;
  assign out_chan.status        = status_r;

  `YMDPC_ASSERT(a_back_load, $rose(out_valid_r) |-> $past(q_pop), "result shown without a queue pop")
  `YMDPC_ASSERT(a_back_missing, (out_valid_r && !parse_ok_r) |-> (status_r == ST_MISSING && year_r == '0), "failed parse not reported as missing")
  `YMDPC_ASSERT(a_back_good, (out_valid_r && status_r == ST_GOOD) |-> (month_present_r && day_present_r), "good date without month and day")

endmodule

// ----- rtl/ymd_date_parse_and_classify.sv -----
// A result goes through the queue write, then the output register, after the transfer
// of its last character; records wait in the queue while out_chan.ready holds the output.
// Throughput: one character per cycle; the classifier, one record per cycle unless held.
// A QUEUE_DEPTH-entry record queue parts scanner and classifier; input stalls while full.
// Reset (rst_n low, synchronous) clears the scan phase, accumulators, queue
// pointers and the result valid; no clearing pass is needed.
module ymd_date_parse_and_classify import ymdpc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = Q_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ymdpc_in_if.sink    in_chan,
  ymdpc_out_if.source out_chan
);

  logic      q_push, q_full, q_pop, q_valid;
  date_rec_t q_wr_rec, q_rd_rec;

  ymdpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_rec   (q_wr_rec)
  );

  ymdpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (q_wr_rec),
    .full   (q_full),
    .pop    (q_pop),
    .rd_rec (q_rd_rec),
    .valid  (q_valid)
  );

  ymdpc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_rec    (q_rd_rec),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
